// File: rtl/atilt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Tilt package
// Shared constants, types and the CORDIC angle table for the tilt block.
// ----------------------------------------------------------------------------
package atilt_pkg;

    localparam int CalSamples = 100;
    localparam int FracBits   = 8;
    localparam int AngFrac    = 16;
    localparam int InScale    = 14;
    localparam int Steps      = 16;

    // CORDIC vector width: 17-bit magnitude scaled by 2^14 plus growth.
    localparam int VW = 36;
    // Angle accumulator width (degrees with 16 fractional bits).
    localparam int AW = 26;
    // Angle width after rounding (degrees with FracBits fractional bits).
    localparam int RW = 17;
    localparam int SW = 24;
    localparam int CW = 7;

    // Offset division by the sample count: multiply by the rounded-up
    // reciprocal scaled by 2^RecipShift, then shift. Exact for sum
    // magnitudes below 2^23.
    localparam int RecipShift = 30;
    localparam logic [SW-1:0] RecipMul =
        SW'(((64'd1 << RecipShift) + 64'(CalSamples) - 64'd1) / 64'(CalSamples));

    localparam logic signed [RW-1:0] AngLim = RW'(180 <<< FracBits);

    // Item kind codes.
    localparam logic KindMeasure = 1'b0;
    localparam logic KindCal     = 1'b1;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;       // capture a new sample
        logic sqrt_step;  // one square-root digit
        logic cord_init;  // set up a CORDIC run (sel picks operands)
        logic cord_step;  // one CORDIC iteration
        logic cord_save;  // store the rounded angle (sel picks target)
        logic sel;        // 0: pitch, 1: roll
        logic div_init;   // capture sum magnitudes and signs
        logic div_step;   // reciprocal multiply for the offsets
        logic finish;     // update calibration state and form the result
    } atilt_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic cal_item;   // current item is a calibration sample
        logic cal_full;   // this calibration item completes the run
    } atilt_sts_t;

    function automatic logic signed [AW-1:0] atan_tab(input logic [3:0] i);
        logic signed [AW-1:0] r;
        unique case (i)
            4'd0:  r = AW'(2949120);
            4'd1:  r = AW'(1740967);
            4'd2:  r = AW'(919879);
            4'd3:  r = AW'(466945);
            4'd4:  r = AW'(234379);
            4'd5:  r = AW'(117304);
            4'd6:  r = AW'(58666);
            4'd7:  r = AW'(29335);
            4'd8:  r = AW'(14668);
            4'd9:  r = AW'(7334);
            4'd10: r = AW'(3667);
            4'd11: r = AW'(1833);
            4'd12: r = AW'(917);
            4'd13: r = AW'(458);
            4'd14: r = AW'(229);
            default: r = AW'(115);
        endcase
        return r;
    endfunction

endpackage
`default_nettype wire

// File: rtl/atilt_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Tilt controller
// Sequences square root, two CORDIC runs, the offset division and output.
// ----------------------------------------------------------------------------
module atilt_ctrl (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_fire,
    input  wire logic                  out_busy,
    input  wire atilt_pkg::atilt_sts_t sts,
    output logic                       in_ready,
    output logic                       out_load,
    output atilt_pkg::atilt_cmd_t      cmd
);
    import atilt_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SQRT  = 3'd1;
    localparam logic [2:0] S_CORD  = 3'd2;
    localparam logic [2:0] S_SAVE  = 3'd3;
    localparam logic [2:0] S_DIV   = 3'd4;
    localparam logic [2:0] S_FIN   = 3'd5;
    localparam logic [2:0] S_OUT   = 3'd6;

    logic [2:0] state_reg, state_next;
    logic [4:0] cnt_reg, cnt_next;
    logic       sel_reg, sel_next;

    // Next-state and command decode.
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        sel_next   = sel_reg;
        cmd        = '0;
        cmd.sel    = sel_reg;
        in_ready   = 1'b0;
        out_load   = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_fire)
                begin
                    cmd.load   = 1'b1;
                    cnt_next   = '0;
                    state_next = S_SQRT;
                end
            end
            S_SQRT:
            begin
                cmd.sqrt_step = 1'b1;
                cnt_next = cnt_reg + 5'd1;
                if (cnt_reg == 5'd15)
                begin
                    sel_next   = 1'b0;
                    state_next = S_CORD;
                    cnt_next   = '0;
                end
            end
            S_CORD:
            begin
                if (cnt_reg == 5'd0)
                    cmd.cord_init = 1'b1;
                else
                    cmd.cord_step = 1'b1;
                cnt_next = cnt_reg + 5'd1;
                if (cnt_reg == 5'd16)
                    state_next = S_SAVE;
            end
            S_SAVE:
            begin
                cmd.cord_save = 1'b1;
                cnt_next = '0;
                if (sel_reg == 1'b0)
                begin
                    sel_next   = 1'b1;
                    state_next = S_CORD;
                end
                else if (sts.cal_item && sts.cal_full)
                    state_next = S_DIV;
                else
                    state_next = S_FIN;
            end
            // The roll angle is stored by now, so the new sums are complete.
            S_DIV:
            begin
                if (cnt_reg == 5'd0)
                    cmd.div_init = 1'b1;
                else
                begin
                    cmd.div_step = 1'b1;
                    state_next   = S_FIN;
                end
                cnt_next = cnt_reg + 5'd1;
            end
            S_FIN:
            begin
                cmd.finish = 1'b1;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (!out_busy)
                begin
                    out_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
            sel_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            sel_reg   <= sel_next;
        end
    end

endmodule
`default_nettype wire

// File: rtl/atilt_dp.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Tilt datapath
// Bit-serial square root, shared CORDIC vectoring unit, reciprocal-multiply
// offset division and the calibration accumulators.
// ----------------------------------------------------------------------------
module atilt_dp (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire atilt_pkg::atilt_cmd_t cmd,
    input  wire logic                  kind,
    input  wire logic signed [15:0]    accel_x,
    input  wire logic signed [15:0]    accel_y,
    input  wire logic signed [15:0]    accel_z,
    output atilt_pkg::atilt_sts_t      sts,
    output logic signed [9:0]          pitch_deg,
    output logic signed [8:0]          roll_deg,
    output logic                       cal_done
);
    import atilt_pkg::*;

    // Sample registers.
    logic                kind_reg;
    logic signed [15:0]  x_reg, y_reg, z_reg;

    // Square root state (32-bit radicand, two bits per step).
    logic [31:0] rad_reg;
    logic [16:0] root_reg;
    logic [17:0] rem_reg;

    // CORDIC state.
    logic signed [VW-1:0] cx_reg, cy_reg;
    logic signed [AW-1:0] acc_reg;
    logic [3:0]           it_reg;
    logic                 zero_reg;

    // Angles.
    logic signed [RW-1:0] pitch_raw_reg, roll_raw_reg;

    // Calibration state.
    logic signed [RW-1:0] pitch_off_reg, roll_off_reg;
    logic signed [SW-1:0] pitch_sum_reg, roll_sum_reg;
    logic [CW-1:0]        cal_cnt_reg;

    // Division state: sum magnitudes, then quotients, with their signs.
    logic [SW-1:0] pq_reg, rq_reg;
    logic          pneg_reg, rneg_reg;

    logic signed [SW-1:0] pitch_sum_new, roll_sum_new;
    assign pitch_sum_new = pitch_sum_reg + SW'(pitch_raw_reg);
    assign roll_sum_new  = roll_sum_reg + SW'(roll_raw_reg);

    assign sts.cal_item = kind_reg;
    assign sts.cal_full = (32'(cal_cnt_reg) + 32'd1 >= 32'(CalSamples));

    // Square root step.
    logic [17:0] rem_sh, trial;
    always_comb
    begin
        rem_sh = {rem_reg[15:0], rad_reg[31:30]};
        trial  = {root_reg[15:0], 2'b01};
    end

    // CORDIC operand setup and step.
    logic signed [VW-1:0] a_in, b_in, sa, sb, nx, ny, dx, dy;
    logic signed [AW-1:0] nacc;
    always_comb
    begin
        if (!cmd.sel)
        begin
            a_in = VW'(z_reg);
            b_in = VW'(y_reg);
        end
        else
        begin
            a_in = VW'($signed({1'b0, root_reg}));
            b_in = -VW'(x_reg);
        end
        sa = a_in <<< InScale;
        sb = b_in <<< InScale;
        nx   = sa;
        ny   = sb;
        nacc = '0;
        if (sa < 0)
        begin
            if (sb >= 0)
            begin
                nx = sb; ny = -sa; nacc = AW'(90 <<< AngFrac);
            end
            else
            begin
                nx = -sb; ny = sa; nacc = -AW'(90 <<< AngFrac);
            end
        end
        dx = cy_reg >>> it_reg;
        dy = cx_reg >>> it_reg;
    end

    // Rounding of the finished angle.
    logic signed [AW-1:0] rnd;
    logic signed [RW-1:0] ang, ang_cl;
    always_comb
    begin
        rnd = (acc_reg + AW'(1 <<< (AngFrac - FracBits - 1))) >>> (AngFrac - FracBits);
        ang = RW'(rnd);
        if (zero_reg)
            ang_cl = '0;
        else if (rnd > AW'(AngLim))
            ang_cl = AngLim;
        else if (rnd < -AW'(AngLim))
            ang_cl = -AngLim;
        else
            ang_cl = ang;
    end

    // Quotient of a magnitude by the sample count via the scaled reciprocal.
    logic [2*SW-1:0] pprod, rprod;
    assign pprod = (2*SW)'(pq_reg) * (2*SW)'(RecipMul);
    assign rprod = (2*SW)'(rq_reg) * (2*SW)'(RecipMul);

    // Offset update values and output.
    logic signed [RW-1:0] p_off_use, r_off_use;
    logic signed [RW:0]   pd, rd;
    logic                 done_now;
    always_comb
    begin
        done_now  = kind_reg && sts.cal_full;
        p_off_use = pitch_off_reg;
        r_off_use = roll_off_reg;
        if (done_now)
        begin
            p_off_use = pneg_reg ? -RW'(pq_reg) : RW'(pq_reg);
            r_off_use = rneg_reg ? -RW'(rq_reg) : RW'(rq_reg);
        end
        pd = (RW+1)'(pitch_raw_reg) - (RW+1)'(p_off_use);
        rd = (RW+1)'(roll_raw_reg) - (RW+1)'(r_off_use);
    end

    logic signed [RW:0] pc, rc;
    assign pc = -((-pd) >>> FracBits);
    assign rc = -((-rd) >>> FracBits);

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            kind_reg <= kind;
            x_reg    <= accel_x;
            y_reg    <= accel_y;
            z_reg    <= accel_z;
            rad_reg  <= 32'(accel_y) * 32'(accel_y) + 32'(accel_z) * 32'(accel_z);
            root_reg <= '0;
            rem_reg  <= '0;
        end
        if (cmd.sqrt_step)
        begin
            rad_reg <= {rad_reg[29:0], 2'b00};
            if (rem_sh >= trial)
            begin
                rem_reg  <= rem_sh - trial;
                root_reg <= {root_reg[15:0], 1'b1};
            end
            else
            begin
                rem_reg  <= rem_sh;
                root_reg <= {root_reg[15:0], 1'b0};
            end
        end
        if (cmd.cord_init)
        begin
            cx_reg   <= nx;
            cy_reg   <= ny;
            acc_reg  <= nacc;
            it_reg   <= '0;
            zero_reg <= (a_in == 0) && (b_in == 0);
        end
        if (cmd.cord_step)
        begin
            it_reg <= it_reg + 4'd1;
            if (cy_reg > 0)
            begin
                cx_reg  <= cx_reg + dx;
                cy_reg  <= cy_reg - dy;
                acc_reg <= acc_reg + atan_tab(it_reg);
            end
            else
            begin
                cx_reg  <= cx_reg - dx;
                cy_reg  <= cy_reg + dy;
                acc_reg <= acc_reg - atan_tab(it_reg);
            end
        end
        if (cmd.cord_save)
        begin
            if (!cmd.sel)
                pitch_raw_reg <= -ang_cl;
            else
                roll_raw_reg <= ang_cl;
        end
        if (cmd.div_init)
        begin
            pneg_reg <= pitch_sum_new[SW-1];
            rneg_reg <= roll_sum_new[SW-1];
            pq_reg   <= pitch_sum_new[SW-1] ? -pitch_sum_new : pitch_sum_new;
            rq_reg   <= roll_sum_new[SW-1] ? -roll_sum_new : roll_sum_new;
        end
        if (cmd.div_step)
        begin
            pq_reg <= SW'(pprod >> RecipShift);
            rq_reg <= SW'(rprod >> RecipShift);
        end
        if (cmd.finish)
        begin
            pitch_deg <= pc[9:0];
            roll_deg  <= rc[8:0];
            cal_done  <= done_now;
        end
    end

    // Calibration state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pitch_off_reg <= '0;
            roll_off_reg  <= '0;
            pitch_sum_reg <= '0;
            roll_sum_reg  <= '0;
            cal_cnt_reg   <= '0;
        end
        else if (cmd.finish && kind_reg == KindCal)
        begin
            if (done_now)
            begin
                pitch_off_reg <= p_off_use;
                roll_off_reg  <= r_off_use;
                pitch_sum_reg <= '0;
                roll_sum_reg  <= '0;
                cal_cnt_reg   <= '0;
            end
            else
            begin
                pitch_sum_reg <= pitch_sum_new;
                roll_sum_reg  <= roll_sum_new;
                cal_cnt_reg   <= cal_cnt_reg + CW'(1);
            end
        end
    end

endmodule
`default_nettype wire

// File: rtl/accel_tilt_with_offset_calibration.sv
`timescale 1ns / 1ps
`default_nettype none
// Sequence: after an input beat is taken, 16 square-root steps, two CORDIC runs
// with a save after each, finish, then the output register load, which waits
// while the previous output beat is still held; the item that completes
// calibration adds the offset division (init, reciprocal multiply) before finish.
// One item in flight: no input beat is taken until the output register has loaded.
// Reset clears offsets, sums, the sample count and the output valid.
// ----------------------------------------------------------------------------
// Accelerometer tilt with offset calibration
// Pitch and roll from a 3-axis sample by CORDIC, with averaged offsets.
// ----------------------------------------------------------------------------
module accel_tilt_with_offset_calibration (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [47:0] s_axis_tdata,  // accel_x, accel_y, accel_z
    input  wire logic        s_axis_tuser,  // kind
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [23:0]      m_axis_tdata,  // pitch_deg, roll_deg, cal_done, zero pad
    output logic             m_axis_tuser
);
    import atilt_pkg::*;

    atilt_cmd_t cmd;
    atilt_sts_t sts;
    logic       in_fire, out_load;
    logic signed [9:0] pitch_deg;
    logic signed [8:0] roll_deg;
    logic              cal_done;

    logic        ovalid_reg;
    logic [23:0] odata_reg;

    assign in_fire = s_axis_tvalid && s_axis_tready;

    atilt_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_fire  (in_fire),
        .out_busy (ovalid_reg && !m_axis_tready),
        .sts      (sts),
        .in_ready (s_axis_tready),
        .out_load (out_load),
        .cmd      (cmd)
    );

    atilt_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .kind      (s_axis_tuser),
        .accel_x   (s_axis_tdata[15:0]),
        .accel_y   (s_axis_tdata[31:16]),
        .accel_z   (s_axis_tdata[47:32]),
        .sts       (sts),
        .pitch_deg (pitch_deg),
        .roll_deg  (roll_deg),
        .cal_done  (cal_done)
    );

    // Output beat register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ovalid_reg <= 1'b0;
        else if (out_load)
            ovalid_reg <= 1'b1;
        else if (m_axis_tready)
            ovalid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
            odata_reg <= {4'b0, cal_done, roll_deg, pitch_deg};
    end

    assign m_axis_tvalid = ovalid_reg;
    assign m_axis_tdata  = odata_reg;
    assign m_axis_tuser  = 1'b0;

endmodule
`default_nettype wire
